/* rtl/core/rdfp_pkg.sv */
// Shared constants and types for the radar data frame parser.
package rdfp_pkg;

    localparam int unsigned KEEP_BYTES = 7;

    localparam logic [23:0] HDR_PREFIX = 24'hF4F3F2;
    localparam logic [7:0]  HDR_LAST   = 8'hF1;
    localparam logic [7:0]  TAIL_FIRST = 8'hF8;
    localparam logic [7:0]  ANGLE_BIAS = 8'h80;
    localparam logic [15:0] MIN_COUNT_LEN = 16'd2;

    typedef logic [KEEP_BYTES-1:0][7:0] kept_t;

    typedef struct packed {
        logic              frame_status;
        logic [7:0]        num_targets;
        logic              alarm;
        logic              target_valid;
        logic signed [7:0] angle_deg;
        logic [7:0]        distance_m;
        logic [7:0]        direction_code;
        logic [7:0]        speed_kmh;
        logic [7:0]        snr_value;
    } result_t;

endpackage

/* rtl/core/rdfp_decode.sv */
// Frame decode: builds one result from the kept payload bytes and tail check.
module rdfp_decode (
    input  rdfp_pkg::kept_t   kept,
    input  logic [15:0]       pay_len,
    input  logic              tail_good,
    output rdfp_pkg::result_t res
);
    import rdfp_pkg::*;

    logic count_ok;
    logic target_ok;

    assign count_ok  = tail_good && (pay_len >= MIN_COUNT_LEN);
    assign target_ok = count_ok && (kept[0] != 8'h00)
                       && (pay_len >= 16'(KEEP_BYTES));

    always_comb
    begin
        res = '0;
        res.frame_status = !tail_good;
        if (count_ok)
        begin
            res.num_targets = kept[0];
            res.alarm       = (kept[1] != 8'h00);
        end
        if (target_ok)
        begin
            res.target_valid   = 1'b1;
            res.angle_deg      = kept[2] - ANGLE_BIAS;
            res.distance_m     = kept[3];
            res.direction_code = kept[4];
            res.speed_kmh      = kept[5];
            res.snr_value      = kept[6];
        end
    end

endmodule

/* rtl/core/radar_data_frame_parser.sv */
// Radar data frame parser top level: byte register, deframer state, result register.
// One received byte per request; a new byte can be taken every clock cycle while
// rx_stall is low. A byte is held in an input register and is processed into the result
// register when it is consumed, so the result of a frame is registered as the input
// register hands over the last tail byte. The result register is the only
// place a frame waits: bytes keep flowing while it is empty or being taken, and
// rx_stall rises only when a result is held by res_stall and a byte is already
// waiting in the input register. Frames are F4 F3 F2 F1, a little-endian 16-bit
// length, the payload (first seven bytes kept) and the tail F8 F7 F6 F5; one result
// per frame, with frame_status set on a bad tail.
module radar_data_frame_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    output logic              rx_stall,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    input  logic              res_stall,
    output logic              frame_status,
    output logic [7:0]        num_targets,
    output logic              alarm,
    output logic              target_valid,
    output logic signed [7:0] angle_deg,
    output logic [7:0]        distance_m,
    output logic [7:0]        direction_code,
    output logic [7:0]        speed_kmh,
    output logic [7:0]        snr_value
);
    import rdfp_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_TAIL
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        byte_valid_reg, byte_valid_next;
    logic [7:0]  byte_reg;
    logic [23:0] recent_reg, recent_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] idx_reg, idx_next;
    logic        tail_ok_reg, tail_ok_next;
    kept_t       kept_reg, kept_next;
    logic        res_valid_reg, res_valid_next;
    result_t     res_reg, res_next;

    logic        consume;
    logic        accept;
    logic        emit;
    logic [15:0] idx_inc;
    logic [15:0] len_full;
    logic        tail_good;
    result_t     decoded;

    assign consume  = byte_valid_reg && (!res_valid_reg || !res_stall);
    assign rx_stall = byte_valid_reg && res_valid_reg && res_stall;
    assign accept   = rx_valid && !rx_stall;
    assign idx_inc  = idx_reg + 16'd1;
    assign len_full = {byte_reg, len_reg[7:0]};
    assign tail_good = tail_ok_reg
                       && (byte_reg == TAIL_FIRST - {6'd0, idx_reg[1:0]});

    rdfp_decode u_decode (
        .kept      (kept_reg),
        .pay_len   (len_reg),
        .tail_good (tail_good),
        .res       (decoded)
    );

    always_comb
    begin
        phase_next   = phase_reg;
        recent_next  = recent_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        tail_ok_next = tail_ok_reg;
        kept_next    = kept_reg;
        emit         = 1'b0;
        if (consume)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (recent_reg == HDR_PREFIX && byte_reg == HDR_LAST)
                    begin
                        recent_next = '0;
                        phase_next  = PH_LEN_LO;
                    end
                    else
                    begin
                        recent_next = {recent_reg[15:0], byte_reg};
                    end
                end
                PH_LEN_LO:
                begin
                    len_next   = {8'd0, byte_reg};
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    len_next     = len_full;
                    idx_next     = '0;
                    tail_ok_next = 1'b1;
                    phase_next   = (len_full == 16'd0) ? PH_TAIL : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    if (idx_reg < 16'(KEEP_BYTES))
                    begin
                        kept_next[idx_reg[2:0]] = byte_reg;
                    end
                    if (idx_inc >= len_reg)
                    begin
                        idx_next   = '0;
                        phase_next = PH_TAIL;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
                PH_TAIL:
                begin
                    if (idx_reg[1:0] == 2'd3)
                    begin
                        emit         = 1'b1;
                        phase_next   = PH_HUNT;
                        idx_next     = '0;
                        tail_ok_next = 1'b1;
                        recent_next  = '0;
                    end
                    else
                    begin
                        idx_next     = idx_inc;
                        tail_ok_next = tail_good;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        if (accept)
        begin
            byte_valid_next = 1'b1;
        end
        else if (consume)
        begin
            byte_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (emit)
        begin
            res_valid_next = 1'b1;
            res_next       = decoded;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            byte_valid_reg <= 1'b0;
            recent_reg     <= '0;
            len_reg        <= '0;
            idx_reg        <= '0;
            tail_ok_reg    <= 1'b1;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_valid_reg <= byte_valid_next;
            recent_reg     <= recent_next;
            len_reg        <= len_next;
            idx_reg        <= idx_next;
            tail_ok_reg    <= tail_ok_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= rx_byte;
        end
        kept_reg <= kept_next;
        res_reg  <= res_next;
    end

    assign res_valid      = res_valid_reg;
    assign frame_status   = res_reg.frame_status;
    assign num_targets    = res_reg.num_targets;
    assign alarm          = res_reg.alarm;
    assign target_valid   = res_reg.target_valid;
    assign angle_deg      = res_reg.angle_deg;
    assign distance_m     = res_reg.distance_m;
    assign direction_code = res_reg.direction_code;
    assign speed_kmh      = res_reg.speed_kmh;
    assign snr_value      = res_reg.snr_value;

    a_bad_tail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && frame_status |-> num_targets == 8'd0 && !alarm && !target_valid)
        else $error("bad-tail result carries data");

    a_target_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && target_valid |-> num_targets != 8'd0)
        else $error("target flagged with zero count");

    a_no_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !target_valid |-> angle_deg == 8'sd0 && distance_m == 8'd0
            && direction_code == 8'd0 && speed_kmh == 8'd0 && snr_value == 8'd0)
        else $error("target fields set without target");

    a_tail_index: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_TAIL |-> idx_reg < 16'd4)
        else $error("tail index out of range");

    a_result_after_tail: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(phase_reg) == PH_TAIL && phase_reg == PH_HUNT)
        else $error("result not caused by last tail byte");

endmodule
